// ===== src/fst_pkg.sv =====
package fst_pkg;

    localparam int POS_W   = 16;
    localparam int CNT_W   = 16;
    localparam int QDEPTH  = 2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_O   = 8'h6F;
    localparam logic [7:0] CH_LC_S   = 8'h73;
    localparam logic [7:0] CH_LC_L   = 8'h6C;
    localparam logic [7:0] CH_UC_L   = 8'h4C;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_D   = 8'h64;
    localparam logic [7:0] CH_UC_D   = 8'h44;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_UC_S   = 8'h53;
    localparam logic [7:0] CH_UC_U   = 8'h55;
    localparam logic [7:0] CH_UC_Q   = 8'h51;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef enum logic [1:0] {
        ST_ELEM = 2'd0,
        ST_END  = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CL_BLANK    = 3'd0,
        CL_DIGIT    = 3'd1,
        CL_SIMPLE   = 3'd2,
        CL_COMPOUND = 3'd3,
        CL_NUL      = 3'd4,
        CL_OTHER    = 3'd5
    } t_cls;

    typedef enum logic [1:0] {
        BK_NONE   = 2'd0,
        BK_ROUND  = 2'd1,
        BK_CURLY  = 2'd2,
        BK_SQUARE = 2'd3
    } t_bkind;

    typedef enum logic [3:0] {
        MODE_TOP    = 4'b0001,
        MODE_OPEN   = 4'b0010,
        MODE_INSIDE = 4'b0100,
        MODE_DONE   = 4'b1000
    } t_mode;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] char_code;
        logic       restart;
        t_cls       cls;
        t_bkind     open_kind;
        t_bkind     close_kind;
    } t_tok;

endpackage

// ===== src/fst_if.sv =====
interface fst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       restart;

    modport source (output valid, output char_code, output restart, input ready);
    modport sink   (input valid, input char_code, input restart, output ready);
endinterface

interface fst_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  identifier;
    logic [15:0] repeat_count;
    logic [15:0] param_start;
    logic [15:0] param_length;

    modport source (output valid, output status, output identifier, output repeat_count,
                    output param_start, output param_length, input ready);
    modport sink   (input valid, input status, input identifier, input repeat_count,
                    input param_start, input param_length, output ready);
endinterface

// ===== src/format_string_tokenizer.sv =====
// Data path: an accepted character is written into the queue; the scanner takes it from
// the queue and registers its result, and a stalled output can hold it there in between.
// Throughput: one character per cycle while the output register is free or being taken.
// Reset: i_rst_n is synchronous and active low; it empties the queue, drops any
// pending result and returns the scanner to top level at position zero.
module format_string_tokenizer #(
    parameter int MAX_NEST = 255,
    parameter int MAX_LEN  = 65535
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fst_in_if.sink     i_in,
    fst_out_if.source  o_out
);

    // The front end classifies each incoming character: blank, digit, simple
    // element letter, compound element letter, NUL or anything else, and it
    // also tags open and close brackets by kind. Classification is pure logic,
    // so the front takes a transaction whenever the queue has room.
    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    fst_pkg::t_tok front_tok;
    fst_pkg::t_tok back_tok;

    fst_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_tok    (front_tok)
    );

    // A short queue of classified characters decouples the two halves, so a
    // stalled output does not immediately stall the character stream.
    fst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (front_tok),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_tok   (back_tok)
    );

    // The back end holds the scan state: repeat count, pending compound letter,
    // bracket kind and nesting depth, and the text start. It consumes one
    // character per cycle whenever its output register is free or being taken.
    // Once end of string or a malformed sequence is reported it consumes
    // characters silently until one arrives with restart set.
    fst_back #(
        .MAX_NEST (MAX_NEST),
        .MAX_LEN  (MAX_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_tok     (back_tok),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ===== src/fst_front.sv =====
module fst_front (
    fst_in_if.sink         i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output fst_pkg::t_tok  o_tok
);

    logic [7:0] c;

    assign c          = i_in.char_code;
    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_tok.char_code = c;
        o_tok.restart   = i_in.restart;

        case (c) inside
            fst_pkg::CH_SPACE: o_tok.cls = fst_pkg::CL_BLANK;
            [fst_pkg::CH_ZERO:fst_pkg::CH_NINE]: o_tok.cls = fst_pkg::CL_DIGIT;
            fst_pkg::CH_LC_O, fst_pkg::CH_LC_S, fst_pkg::CH_LC_L, fst_pkg::CH_UC_L,
            fst_pkg::CH_LC_F, fst_pkg::CH_LC_D, fst_pkg::CH_UC_D, fst_pkg::CH_LC_E:
                o_tok.cls = fst_pkg::CL_SIMPLE;
            fst_pkg::CH_UC_S, fst_pkg::CH_UC_U, fst_pkg::CH_UC_Q:
                o_tok.cls = fst_pkg::CL_COMPOUND;
            fst_pkg::CH_NUL: o_tok.cls = fst_pkg::CL_NUL;
            default: o_tok.cls = fst_pkg::CL_OTHER;
        endcase

        case (c)
            fst_pkg::CH_LPAREN: o_tok.open_kind = fst_pkg::BK_ROUND;
            fst_pkg::CH_LBRACE: o_tok.open_kind = fst_pkg::BK_CURLY;
            fst_pkg::CH_LBRACK: o_tok.open_kind = fst_pkg::BK_SQUARE;
            default:            o_tok.open_kind = fst_pkg::BK_NONE;
        endcase

        case (c)
            fst_pkg::CH_RPAREN: o_tok.close_kind = fst_pkg::BK_ROUND;
            fst_pkg::CH_RBRACE: o_tok.close_kind = fst_pkg::BK_CURLY;
            fst_pkg::CH_RBRACK: o_tok.close_kind = fst_pkg::BK_SQUARE;
            default:            o_tok.close_kind = fst_pkg::BK_NONE;
        endcase
    end

endmodule

// ===== src/fst_queue.sv =====
module fst_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fst_pkg::t_tok  i_tok,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output fst_pkg::t_tok  o_tok
);

    localparam int AW = (fst_pkg::QDEPTH > 1) ? $clog2(fst_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(fst_pkg::QDEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(fst_pkg::QDEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(fst_pkg::QDEPTH - 1);

    fst_pkg::t_tok r_mem [fst_pkg::QDEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_tok   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");

endmodule

// ===== src/fst_back.sv =====
module fst_back #(
    parameter int MAX_NEST = 255,
    parameter int MAX_LEN  = 65535
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  fst_pkg::t_tok  i_tok,
    output logic           o_pop,
    fst_out_if.source      o_out
);

    localparam int DW = $clog2(MAX_NEST + 1);
    localparam logic [DW-1:0] NEST_MAX = DW'(MAX_NEST);
    localparam logic [fst_pkg::POS_W-1:0] LEN_MAX = fst_pkg::POS_W'(MAX_LEN);

    fst_pkg::t_mode               r_mode,    n_mode,    e_mode;
    logic [fst_pkg::POS_W-1:0]    r_pos,     n_pos,     e_pos;
    logic [fst_pkg::CNT_W-1:0]    r_acc,     n_acc,     e_acc;
    logic [7:0]                   r_letter,  n_letter,  e_letter;
    fst_pkg::t_bkind              r_kind,    n_kind,    e_kind;
    logic [DW-1:0]                r_depth,   n_depth,   e_depth;
    logic [fst_pkg::POS_W-1:0]    r_start,   n_start,   e_start;

    logic                         r_out_valid;
    fst_pkg::t_status             r_status,  n_status;
    logic [7:0]                   r_ident,   n_ident;
    logic [fst_pkg::CNT_W-1:0]    r_rep,     n_rep;
    logic [fst_pkg::POS_W-1:0]    r_pstart,  n_pstart;
    logic [fst_pkg::POS_W-1:0]    r_plen,    n_plen;
    logic                         n_emit;

    logic [fst_pkg::CNT_W-1:0]    taken_cnt;
    logic [DW-1:0]                depth_upd;

    assign o_pop = !i_q_empty && (!r_out_valid || o_out.ready);

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.identifier   = r_ident;
    assign o_out.repeat_count = r_rep;
    assign o_out.param_start  = r_pstart;
    assign o_out.param_length = r_plen;

    // A restart character sees the reset state.
    always_comb begin
        if (i_tok.restart) begin
            e_mode   = fst_pkg::MODE_TOP;
            e_pos    = '0;
            e_acc    = '0;
            e_letter = '0;
            e_kind   = fst_pkg::BK_NONE;
            e_depth  = '0;
            e_start  = '0;
        end else begin
            e_mode   = r_mode;
            e_pos    = r_pos;
            e_acc    = r_acc;
            e_letter = r_letter;
            e_kind   = r_kind;
            e_depth  = r_depth;
            e_start  = r_start;
        end
    end

    assign taken_cnt = (e_acc == '0) ? fst_pkg::CNT_W'(1) : e_acc;

    always_comb begin
        n_mode   = e_mode;
        n_pos    = e_pos + fst_pkg::POS_W'(1);
        n_acc    = e_acc;
        n_letter = e_letter;
        n_kind   = e_kind;
        n_depth  = e_depth;
        n_start  = e_start;
        n_emit   = 1'b0;
        n_status = fst_pkg::ST_ELEM;
        n_ident  = '0;
        n_rep    = '0;
        n_pstart = '0;
        n_plen   = '0;
        depth_upd = e_depth;

        if (e_mode == fst_pkg::MODE_DONE) begin
            n_pos = e_pos;
        end else if (e_pos >= LEN_MAX) begin
            n_mode   = fst_pkg::MODE_DONE;
            n_pos    = e_pos;
            n_emit   = 1'b1;
            n_status = fst_pkg::ST_BAD;
        end else begin
            case (e_mode)
                fst_pkg::MODE_TOP: begin
                    case (i_tok.cls)
                        fst_pkg::CL_BLANK: begin
                        end
                        fst_pkg::CL_DIGIT: begin
                            n_acc = {e_acc[fst_pkg::CNT_W-4:0], 3'b000}
                                  + {e_acc[fst_pkg::CNT_W-2:0], 1'b0}
                                  + {{(fst_pkg::CNT_W-4){1'b0}}, i_tok.char_code[3:0]};
                        end
                        fst_pkg::CL_SIMPLE: begin
                            n_emit  = 1'b1;
                            n_ident = i_tok.char_code;
                            n_rep   = taken_cnt;
                            n_acc   = '0;
                        end
                        fst_pkg::CL_COMPOUND: begin
                            n_letter = i_tok.char_code;
                            n_mode   = fst_pkg::MODE_OPEN;
                        end
                        fst_pkg::CL_NUL: begin
                            n_mode   = fst_pkg::MODE_DONE;
                            n_pos    = e_pos;
                            n_emit   = 1'b1;
                            n_status = fst_pkg::ST_END;
                        end
                        default: begin
                            n_mode   = fst_pkg::MODE_DONE;
                            n_pos    = e_pos;
                            n_emit   = 1'b1;
                            n_status = fst_pkg::ST_BAD;
                        end
                    endcase
                end
                fst_pkg::MODE_OPEN: begin
                    if (i_tok.open_kind == fst_pkg::BK_NONE) begin
                        n_mode   = fst_pkg::MODE_DONE;
                        n_pos    = e_pos;
                        n_emit   = 1'b1;
                        n_status = fst_pkg::ST_BAD;
                    end else begin
                        n_kind  = i_tok.open_kind;
                        n_depth = DW'(1);
                        n_start = e_pos + fst_pkg::POS_W'(1);
                        n_mode  = fst_pkg::MODE_INSIDE;
                    end
                end
                fst_pkg::MODE_INSIDE: begin
                    if (i_tok.cls == fst_pkg::CL_NUL) begin
                        n_mode   = fst_pkg::MODE_DONE;
                        n_pos    = e_pos;
                        n_emit   = 1'b1;
                        n_status = fst_pkg::ST_BAD;
                    end else if (i_tok.open_kind == e_kind && e_depth >= NEST_MAX) begin
                        n_mode   = fst_pkg::MODE_DONE;
                        n_pos    = e_pos;
                        n_emit   = 1'b1;
                        n_status = fst_pkg::ST_BAD;
                    end else begin
                        if (i_tok.close_kind == e_kind) begin
                            depth_upd = e_depth - DW'(1);
                        end else if (i_tok.open_kind == e_kind) begin
                            depth_upd = e_depth + DW'(1);
                        end
                        n_depth = depth_upd;
                        if (depth_upd == '0) begin
                            n_emit   = 1'b1;
                            n_ident  = e_letter;
                            n_rep    = taken_cnt;
                            n_acc    = '0;
                            n_pstart = e_start;
                            n_plen   = e_pos - e_start;
                            n_mode   = fst_pkg::MODE_TOP;
                            n_kind   = fst_pkg::BK_NONE;
                        end
                    end
                end
                default: begin
                    n_pos = e_pos;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= fst_pkg::MODE_TOP;
            r_pos       <= '0;
            r_acc       <= '0;
            r_letter    <= '0;
            r_kind      <= fst_pkg::BK_NONE;
            r_depth     <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode      <= n_mode;
                r_pos       <= n_pos;
                r_acc       <= n_acc;
                r_letter    <= n_letter;
                r_kind      <= n_kind;
                r_depth     <= n_depth;
                r_start     <= n_start;
                r_out_valid <= n_emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && n_emit) begin
            r_status <= n_status;
            r_ident  <= n_ident;
            r_rep    <= n_rep;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
        end
    end

    a_elem_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == fst_pkg::ST_ELEM) |-> (r_rep != '0))
        else $error("element reported with zero repeat count");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_mode == fst_pkg::MODE_DONE && !i_tok.restart) |=> !r_out_valid)
        else $error("result produced after end of string");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= NEST_MAX)
        else $error("nesting depth beyond bound");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LEN_MAX)
        else $error("position beyond bound");

endmodule

// ===== test/format_string_tokenizer_tb.sv =====
module format_string_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fst_pkg::*;

    // The block is built with its default bounds, so the scanner below uses the same ones.
    localparam int MAX_NEST    = 255;
    localparam int MAX_LEN     = 65535;
    localparam int RAND_ITEMS  = 250;
    localparam int HOLD_CYCLES = 300;

    // Letter sets, packed so that a random index picks one byte out of each.
    // The open and close sets are in the same order, so one index gives a matched pair.
    localparam logic [63:0] SIMPLE_SET   = {CH_LC_O, CH_LC_S, CH_LC_L, CH_UC_L,
                                            CH_LC_F, CH_LC_D, CH_UC_D, CH_LC_E};
    localparam logic [23:0] COMPOUND_SET = {CH_UC_S, CH_UC_U, CH_UC_Q};
    localparam logic [23:0] OPEN_SET     = {CH_LPAREN, CH_LBRACE, CH_LBRACK};
    localparam logic [23:0] CLOSE_SET    = {CH_RPAREN, CH_RBRACE, CH_RBRACK};

    // One token report as it leaves the block.
    typedef struct packed {
        t_status     status;
        logic [7:0]  ident;
        logic [15:0] rcount;
        logic [15:0] pstart;
        logic [15:0] plen;
    } t_res;

    // One row of the directed table. Rows with fixed set carry their own expectation;
    // the others are left to the scanner model.
    typedef struct packed {
        logic [7:0] ch;
        logic       rs;
        logic       fixed;
        logic       has_res;
        t_res       res;
    } t_row;

    // Styles of the receiver's ready pattern.
    typedef enum logic [1:0] {
        RX_FULL,
        RX_EVERY_FOURTH,
        RX_SPARSE,
        RX_RANDOM
    } t_rx_style;

    logic i_clk;
    logic i_rst_n;

    fst_in_if  char_ch ();
    fst_out_if res_ch ();

    format_string_tokenizer #(
        .MAX_NEST (MAX_NEST),
        .MAX_LEN  (MAX_LEN)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_ch),
        .o_out   (res_ch)
    );

    // Scanner model state, a private copy of what the block keeps.
    t_mode       sc_mode;
    logic [15:0] sc_pos;
    logic [15:0] sc_count;
    logic [7:0]  sc_letter;
    t_bkind      sc_kind;
    int unsigned sc_depth;
    logic [15:0] sc_tstart;

    // Reports still owed by the block, oldest first.
    t_res token_q [$];

    // Characters of the string being played, with the restart flag in bit 8.
    logic [8:0] seq_q [$];

    t_row dir_rows [$];

    int errors     = 0;
    int n_chars    = 0;
    int n_elem     = 0;
    int n_end      = 0;
    int n_bad      = 0;
    int burst_left = 0;

    // The main process asks for a long receiver stall by bumping hold_ticket;
    // the receiver notices the change and counts the stall itself.
    int        hold_ticket = 0;
    int        hold_seen   = 0;
    int        hold_left   = 0;
    t_rx_style rx_style    = RX_FULL;
    int        rx_seg      = 0;
    int        rx_tick     = 0;

    t_res got_res;
    t_res want_res;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------

    function automatic t_res mk_res(t_status st, logic [7:0] id, logic [15:0] cnt,
                                    logic [15:0] start, logic [15:0] len);
        t_res r;
        r.status = st;
        r.ident  = id;
        r.rcount = cnt;
        r.pstart = start;
        r.plen   = len;
        return r;
    endfunction

    function automatic void scan_clear();
        sc_mode   = MODE_TOP;
        sc_pos    = '0;
        sc_count  = '0;
        sc_letter = '0;
        sc_kind   = BK_NONE;
        sc_depth  = 0;
        sc_tstart = '0;
    endfunction

    // A repeat count of zero, given or implied, means one.
    function automatic logic [15:0] take_count();
        logic [15:0] n;
        n        = sc_count;
        sc_count = '0;
        return (n == 16'd0) ? 16'd1 : n;
    endfunction

    // End of string or malformed input: the scanner goes quiet until a restart.
    function automatic bit end_scan(input t_status st, output t_res r);
        sc_mode = MODE_DONE;
        r       = mk_res(st, 8'd0, 16'd0, 16'd0, 16'd0);
        return 1'b1;
    endfunction

    function automatic bit is_simple_letter(logic [7:0] c);
        case (c)
            CH_LC_O, CH_LC_S, CH_LC_L, CH_UC_L,
            CH_LC_F, CH_LC_D, CH_UC_D, CH_LC_E: return 1'b1;
            default:                            return 1'b0;
        endcase
    endfunction

    // Advances the model by one accepted character. Returns 1 when the character
    // produces a report, which is then left in r.
    function automatic bit scan_char(input logic [7:0] c, input logic rs, output t_res r);
        logic [15:0] p;
        logic [7:0]  opn;
        logic [7:0]  cls;
        bit          hit;
        r   = mk_res(ST_ELEM, 8'd0, 16'd0, 16'd0, 16'd0);
        hit = 1'b0;
        if (rs) begin
            scan_clear();
        end
        if (sc_mode == MODE_DONE) begin
            return 1'b0;
        end
        p = sc_pos;
        // Any character landing at or beyond the length bound is malformed.
        if (int'(p) >= MAX_LEN) begin
            return end_scan(ST_BAD, r);
        end
        case (sc_mode)
            MODE_TOP: begin
                if (c == CH_SPACE) begin
                    // Blanks separate nothing and are dropped.
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    // The count wraps at 16 bits, like the block's register.
                    sc_count = sc_count * 16'd10 + 16'(c - CH_ZERO);
                end else if (is_simple_letter(c)) begin
                    r   = mk_res(ST_ELEM, c, take_count(), 16'd0, 16'd0);
                    hit = 1'b1;
                end else if (c == CH_UC_S || c == CH_UC_U || c == CH_UC_Q) begin
                    sc_letter = c;
                    sc_mode   = MODE_OPEN;
                end else if (c == CH_NUL) begin
                    return end_scan(ST_END, r);
                end else begin
                    return end_scan(ST_BAD, r);
                end
            end
            MODE_OPEN: begin
                // The bracket has to follow the compound letter at once.
                case (c)
                    CH_LPAREN: sc_kind = BK_ROUND;
                    CH_LBRACE: sc_kind = BK_CURLY;
                    CH_LBRACK: sc_kind = BK_SQUARE;
                    default:   return end_scan(ST_BAD, r);
                endcase
                sc_depth  = 1;
                sc_tstart = p + 16'd1;
                sc_mode   = MODE_INSIDE;
            end
            default: begin
                // Inside brackets only the opening kind counts; other brackets are text.
                case (sc_kind)
                    BK_ROUND: begin
                        opn = CH_LPAREN;
                        cls = CH_RPAREN;
                    end
                    BK_CURLY: begin
                        opn = CH_LBRACE;
                        cls = CH_RBRACE;
                    end
                    default: begin
                        opn = CH_LBRACK;
                        cls = CH_RBRACK;
                    end
                endcase
                if (c == CH_NUL) begin
                    return end_scan(ST_BAD, r);
                end
                if (c == cls) begin
                    sc_depth--;
                end else if (c == opn) begin
                    if (sc_depth >= MAX_NEST) begin
                        return end_scan(ST_BAD, r);
                    end
                    sc_depth++;
                end
                if (sc_depth == 0) begin
                    r       = mk_res(ST_ELEM, sc_letter, take_count(), sc_tstart, p - sc_tstart);
                    hit     = 1'b1;
                    sc_mode = MODE_TOP;
                    sc_kind = BK_NONE;
                end
            end
        endcase
        sc_pos = p + 16'd1;
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one character and returns at the edge where it is accepted. Traffic comes
    // in bursts; valid drops only when a real gap follows, so a back-to-back burst never
    // sees valid lowered and raised in the same time step.
    task automatic put_char(input logic [7:0] c, input logic rs);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 128)
                                                      : $urandom_range(1, 16);
            if (gap != 0) begin
                char_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        char_ch.restart   <= rs;
        do @(posedge i_clk); while (char_ch.ready !== 1'b1);
        n_chars++;
    endtask

    // Sends a character and records what the model says it must produce.
    task automatic feed(input logic [7:0] c, input logic rs);
        t_res r;
        put_char(c, rs);
        if (scan_char(c, rs, r)) begin
            token_q.push_back(r);
        end
    endtask

    // Stops offering and waits for every outstanding report. The wait always runs on the
    // clock, so the next valid rise never shares a time step with this drop.
    task automatic drain();
        char_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (token_q.size() != 0);
    endtask

    // A byte that is plain text inside the given bracket pair.
    function automatic logic [7:0] plain_byte(logic [7:0] opn, logic [7:0] cls);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == opn || c == cls);
        return c;
    endfunction

    // Appends one well-formed element: optional blanks, optional count, then either a
    // simple letter or a compound letter with a balanced bracket body.
    task automatic add_element();
        int         depth;
        int         k;
        int         j;
        logic [7:0] opn;
        logic [7:0] cls;
        repeat ($urandom_range(0, 2)) seq_q.push_back({1'b0, CH_SPACE});
        // Mostly short counts; now and then enough digits to wrap the count.
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 2))
            seq_q.push_back({1'b0, 8'(CH_ZERO + $urandom_range(0, 9))});
        if ($urandom_range(0, 1) == 0) begin
            k = $urandom_range(0, 7);
            seq_q.push_back({1'b0, SIMPLE_SET[8*k +: 8]});
        end else begin
            k   = $urandom_range(0, 2);
            j   = $urandom_range(0, 2);
            opn = OPEN_SET[8*k +: 8];
            cls = CLOSE_SET[8*k +: 8];
            seq_q.push_back({1'b0, COMPOUND_SET[8*j +: 8]});
            seq_q.push_back({1'b0, opn});
            depth = 0;
            repeat ($urandom_range(0, 12)) begin
                j = $urandom_range(0, 5);
                if (j == 0 && depth < 6) begin
                    seq_q.push_back({1'b0, opn});
                    depth++;
                end else if (j == 1 && depth > 0) begin
                    seq_q.push_back({1'b0, cls});
                    depth--;
                end else begin
                    seq_q.push_back({1'b0, plain_byte(opn, cls)});
                end
            end
            repeat (depth + 1) seq_q.push_back({1'b0, cls});
        end
    endtask

    // Builds one random string into seq_q. Most strings are well formed; some are
    // damaged in one of several ways, and a few are pure noise.
    task automatic build_string();
        int         pick;
        int         idx;
        logic [7:0] c;
        seq_q.delete();
        pick = $urandom_range(0, 9);
        if (pick == 9) begin
            repeat ($urandom_range(1, 10)) seq_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        end else begin
            repeat ($urandom_range(1, 8)) add_element();
            if (pick < 7) begin
                // Usually terminated; an unterminated string is cut by the next restart.
                if ($urandom_range(0, 7) != 0) begin
                    seq_q.push_back({1'b0, CH_NUL});
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        // Overwrite one character with any byte at all.
                        idx        = $urandom_range(0, seq_q.size() - 1);
                        seq_q[idx] = {seq_q[idx][8], 8'($urandom_range(0, 255))};
                    end
                    1: begin
                        // Start a new string in the middle of this one.
                        idx           = $urandom_range(0, seq_q.size() - 1);
                        seq_q[idx][8] = 1'b1;
                    end
                    2: begin
                        // Compound letter followed by something that is not an open bracket.
                        seq_q.push_back({1'b0, COMPOUND_SET[8*$urandom_range(0, 2) +: 8]});
                        do c = 8'($urandom_range(0, 255));
                        while (c == CH_LPAREN || c == CH_LBRACE || c == CH_LBRACK);
                        seq_q.push_back({1'b0, c});
                    end
                    default: begin
                        // String ends while a bracket is still open.
                        idx = $urandom_range(0, 2);
                        seq_q.push_back({1'b0, COMPOUND_SET[8*idx +: 8]});
                        seq_q.push_back({1'b0, OPEN_SET[8*idx +: 8]});
                        repeat ($urandom_range(0, 4))
                            seq_q.push_back({1'b0, plain_byte(OPEN_SET[8*idx +: 8],
                                                              CLOSE_SET[8*idx +: 8])});
                        seq_q.push_back({1'b0, CH_NUL});
                    end
                endcase
            end
            // Characters after the end must be swallowed without a report.
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) seq_q.push_back({1'b0, 8'($urandom_range(0, 255))});
            end
        end
        seq_q[0][8] = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Ready follows segments of different styles. A long stall requested by the main
    // process overrides the pattern and is counted down here.
    always @(posedge i_clk) begin
        if (hold_seen != hold_ticket) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            if (rx_seg == 0) begin
                rx_style = t_rx_style'($urandom_range(0, 3));
                rx_seg   = $urandom_range(8, 80);
            end
            rx_seg--;
            rx_tick++;
            case (rx_style)
                RX_FULL:         res_ch.ready <= 1'b1;
                RX_EVERY_FOURTH: res_ch.ready <= (rx_tick % 4) != 3;
                RX_SPARSE:       res_ch.ready <= (rx_tick % 5) == 0;
                default:         res_ch.ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    function automatic void check_field(string fld, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, fld, want, got);
        end
    endfunction

    // Every transaction on the output is compared against the oldest owed report.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got_res = mk_res(t_status'(res_ch.status), res_ch.identifier,
                             res_ch.repeat_count, res_ch.param_start, res_ch.param_length);
            case (got_res.status)
                ST_ELEM: n_elem++;
                ST_END:  n_end++;
                default: n_bad++;
            endcase
            if (token_q.size() == 0) begin
                errors++;
                $display("%0t: no result expected, got st %0d id %0h cnt %0d start %0d len %0d",
                         $time, got_res.status, got_res.ident, got_res.rcount,
                         got_res.pstart, got_res.plen);
            end else begin
                want_res = token_q.pop_front();
                check_field("status", 16'(want_res.status), 16'(got_res.status));
                check_field("identifier", 16'(want_res.ident), 16'(got_res.ident));
                check_field("repeat_count", want_res.rcount, got_res.rcount);
                check_field("param_start", want_res.pstart, got_res.pstart);
                check_field("param_length", want_res.plen, got_res.plen);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic t_row chr_row(logic [7:0] c, logic rs);
        t_row w;
        w         = '0;
        w.ch      = c;
        w.rs      = rs;
        return w;
    endfunction

    function automatic t_row res_row(logic [7:0] c, logic rs, logic has, t_res res);
        t_row w;
        w         = '0;
        w.ch      = c;
        w.rs      = rs;
        w.fixed   = 1'b1;
        w.has_res = has;
        w.res     = res;
        return w;
    endfunction

    initial begin
        t_res r;
        bit   hit;
        int   rand_items;

        i_rst_n           = 1'b0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = CH_NUL;
        char_ch.restart   = 1'b0;
        scan_clear();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. The rows walk every simple letter, interleaved with a zero count,
        // a count that wraps and a nested compound with foreign brackets inside, then a missing
        // bracket, silence after a malformed string, a clean end, a high byte, and a
        // NUL inside brackets.
        dir_rows.push_back(res_row(CH_LC_O, 1'b1, 1'b1,
                                   mk_res(ST_ELEM, CH_LC_O, 16'd1, 16'd0, 16'd0)));
        dir_rows.push_back(res_row(CH_LC_S, 1'b0, 1'b1,
                                   mk_res(ST_ELEM, CH_LC_S, 16'd1, 16'd0, 16'd0)));
        dir_rows.push_back(res_row(CH_LC_L, 1'b0, 1'b1,
                                   mk_res(ST_ELEM, CH_LC_L, 16'd1, 16'd0, 16'd0)));
        dir_rows.push_back(res_row(CH_UC_L, 1'b0, 1'b1,
                                   mk_res(ST_ELEM, CH_UC_L, 16'd1, 16'd0, 16'd0)));
        dir_rows.push_back(res_row(CH_LC_F, 1'b0, 1'b1,
                                   mk_res(ST_ELEM, CH_LC_F, 16'd1, 16'd0, 16'd0)));
        dir_rows.push_back(chr_row(CH_ZERO, 1'b0));
        dir_rows.push_back(res_row(CH_LC_D, 1'b0, 1'b1,
                                   mk_res(ST_ELEM, CH_LC_D, 16'd1, 16'd0, 16'd0)));
        dir_rows.push_back(chr_row(CH_SPACE, 1'b0));
        repeat (5) dir_rows.push_back(chr_row(CH_NINE, 1'b0));
        dir_rows.push_back(chr_row(CH_UC_D, 1'b0));
        dir_rows.push_back(chr_row("2", 1'b0));
        dir_rows.push_back(chr_row(CH_UC_U, 1'b0));
        dir_rows.push_back(chr_row(CH_LBRACE, 1'b0));
        dir_rows.push_back(chr_row(CH_LPAREN, 1'b0));
        dir_rows.push_back(chr_row(CH_LBRACE, 1'b0));
        dir_rows.push_back(chr_row(CH_RBRACE, 1'b0));
        dir_rows.push_back(chr_row(CH_RBRACE, 1'b0));
        dir_rows.push_back(res_row(CH_LC_E, 1'b0, 1'b1,
                                   mk_res(ST_ELEM, CH_LC_E, 16'd1, 16'd0, 16'd0)));
        dir_rows.push_back(chr_row(CH_UC_Q, 1'b0));
        dir_rows.push_back(res_row("x", 1'b0, 1'b1,
                                   mk_res(ST_BAD, 8'd0, 16'd0, 16'd0, 16'd0)));
        dir_rows.push_back(res_row(CH_LC_L, 1'b0, 1'b0, '0));
        dir_rows.push_back(res_row(CH_NUL, 1'b1, 1'b1,
                                   mk_res(ST_END, 8'd0, 16'd0, 16'd0, 16'd0)));
        dir_rows.push_back(res_row(8'hFF, 1'b1, 1'b1,
                                   mk_res(ST_BAD, 8'd0, 16'd0, 16'd0, 16'd0)));
        dir_rows.push_back(chr_row(CH_UC_S, 1'b1));
        dir_rows.push_back(chr_row(CH_LBRACK, 1'b0));
        dir_rows.push_back(res_row(CH_NUL, 1'b0, 1'b1,
                                   mk_res(ST_BAD, 8'd0, 16'd0, 16'd0, 16'd0)));

        // The model always advances so its state stays in step; a typed row replaces
        // only the expectation it would have pushed.
        foreach (dir_rows[i]) begin
            put_char(dir_rows[i].ch, dir_rows[i].rs);
            hit = scan_char(dir_rows[i].ch, dir_rows[i].rs, r);
            if (dir_rows[i].fixed) begin
                if (dir_rows[i].has_res) begin
                    token_q.push_back(dir_rows[i].res);
                end
            end else if (hit) begin
                token_q.push_back(r);
            end
        end
        drain();

        // Back pressure: the receiver stalls for a long stretch while every character
        // produces a report, so the block fills up and must hold off its input.
        hold_ticket <= hold_ticket + 1;
        feed(CH_LC_O, 1'b1);
        repeat (59) feed(CH_LC_O, 1'b0);
        feed(CH_NUL, 1'b0);
        drain();

        // Random strings, with an occasional full pause of the sender.
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            build_string();
            rand_items += seq_q.size();
            foreach (seq_q[i]) begin
                feed(seq_q[i][7:0], seq_q[i][8]);
            end
            if ($urandom_range(0, 9) == 0) begin
                drain();
            end
        end

        // Nesting climbs right up to the bound without complaint; one level more
        // is malformed.
        feed(CH_UC_S, 1'b1);
        feed(CH_LPAREN, 1'b0);
        repeat (MAX_NEST) feed(CH_LPAREN, 1'b0);

        drain();
        // Run on after the drain so that a stray report after the last one would be caught.
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d characters: %0d elements, %0d end markers, %0d malformed.",
                 n_chars, n_elem, n_end, n_bad);
        $display("Included directed rows, a long output stall and nesting up to and past its bound.");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
